// ===== hdl/fcspd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcspd_pkg
// Shared types and constants for the four-channel servo pulse decoder.
// ----------------------------------------------------------------------------
package fcspd_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned WIDTH_W  = 15;
  localparam int unsigned US_PER_MS = 1000;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

  localparam int unsigned IN_DATA_W  = 2 * NUM_CH + NUM_CH * CAP_W;
  localparam int unsigned OUT_DATA_W = NUM_CH * WIDTH_W + NUM_CH;

  // pipeline advance controls handed to every lane
  typedef struct packed {
    logic load;
    logic adv1;
    logic adv2;
  } fcspd_ctrl_t;

  // what one lane reports to the merging stage
  typedef struct packed {
    logic               upd;
    logic [WIDTH_W-1:0] width;
  } fcspd_lane_res_t;

endpackage

// ===== hdl/fcspd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcspd_lane
// One channel: lead capture state, tick difference and tick-to-microsecond
// conversion by reciprocal multiplication.
// ----------------------------------------------------------------------------
module fcspd_lane #(
  parameter int unsigned TICKS_PER_MS = 3000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcspd_pkg::fcspd_ctrl_t        ctrl_i,
  input  logic                          event_i,
  input  logic                          level_i,
  input  logic                          polarity_i,
  input  logic [fcspd_pkg::CAP_W-1:0]   capture_i,
  output fcspd_pkg::fcspd_lane_res_t    res_o
);
  import fcspd_pkg::*;

  localparam int unsigned N_W    = $clog2(((2 ** CAP_W) - 1) * US_PER_MS + 1);
  localparam int unsigned SHIFT  = N_W + $clog2(TICKS_PER_MS);
  localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + TICKS_PER_MS - 1) / TICKS_PER_MS;
  localparam int unsigned M_W    = $clog2(RECIP_L + 1);
  localparam int unsigned PROD_W = N_W + M_W;
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);
  localparam logic [N_W-1:0] SCALE = N_W'(US_PER_MS);

  logic [CAP_W-1:0] lead_count_q;
  logic             lead_valid_q;
  logic [CAP_W-1:0] diff1_q;
  logic             upd1_q;
  logic [N_W-1:0]   n2_q;
  logic             upd2_q;

  logic             hit;
  logic             lead;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;

  assign hit  = ctrl_i.load & event_i;
  assign lead = level_i ^ polarity_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_count_q <= '0;
      lead_valid_q <= 1'b0;
    end else if (hit) begin
      if (lead) begin
        lead_count_q <= capture_i;
      end
      lead_valid_q <= lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd1_q <= 1'b0;
      upd2_q <= 1'b0;
    end else begin
      if (ctrl_i.adv1) begin
        upd1_q <= hit & ~lead;
      end
      if (ctrl_i.adv2) begin
        upd2_q <= upd1_q;
      end
    end
  end

  // trailing edge without a lead converts a zero difference
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      diff1_q <= (hit && !lead && lead_valid_q) ? capture_i - lead_count_q : '0;
    end
    if (ctrl_i.adv2) begin
      n2_q <= N_W'(diff1_q) * SCALE;
    end
  end

  always_comb begin
    prod = {{M_W{1'b0}}, n2_q} * {{N_W{1'b0}}, RECIP};
    quot = prod >> SHIFT;
    res_o.upd = upd2_q;
    if (|quot[PROD_W-1:WIDTH_W]) begin
      res_o.width = WIDTH_MAX;
    end else begin
      res_o.width = quot[WIDTH_W-1:0];
    end
  end

endmodule

// ===== hdl/four_channel_servo_pulse_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_servo_pulse_decoder_core
// Four-lane servo pulse-width capture with a merging output stage.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless m_axis_tready stalls the output;
//   lead state updates on acceptance, the tick difference, scaling multiply and
//   reciprocal multiply are staged ahead of the output register.
// Reset: asynchronous, active low; clears polarity, lead state, widths and
//   all pipeline valid flags.
// ----------------------------------------------------------------------------
module four_channel_servo_pulse_decoder_core #(
  parameter int unsigned TICKS_PER_MS = 3000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcspd_pkg::NUM_CH-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // event_mask[3:0], pin_levels[7:4], capture_ch1..capture_ch4 [71:8]
  input  logic [fcspd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // width_ch1..width_ch4 [59:0], updated_mask [63:60]
  output logic [fcspd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import fcspd_pkg::*;

  logic [NUM_CH-1:0]  polarity_q;
  logic               v1_q, v2_q, ov_q;
  logic               en1, en2, en3, acc;
  fcspd_ctrl_t        ctrl;
  fcspd_lane_res_t    res [NUM_CH];
  logic [WIDTH_W-1:0] width_q [NUM_CH];
  logic [WIDTH_W-1:0] width_d [NUM_CH];
  logic [NUM_CH-1:0]  upd;
  logic [OUT_DATA_W-1:0] out_q, out_d;

  assign en3 = ~ov_q | m_axis_tready;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign acc = s_axis_tvalid & en1;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  assign ctrl.load = acc;
  assign ctrl.adv1 = en1;
  assign ctrl.adv2 = en2;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    fcspd_lane #(
      .TICKS_PER_MS (TICKS_PER_MS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .event_i    (s_axis_tdata[g]),
      .level_i    (s_axis_tdata[NUM_CH + g]),
      .polarity_i (polarity_q[g]),
      .capture_i  (s_axis_tdata[2*NUM_CH + g*CAP_W +: CAP_W]),
      .res_o      (res[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      upd[i]     = v2_q & res[i].upd;
      width_d[i] = upd[i] ? res[i].width : width_q[i];
      out_d[i*WIDTH_W +: WIDTH_W] = width_d[i];
    end
    out_d[NUM_CH*WIDTH_W +: NUM_CH] = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      ov_q       <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        width_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        polarity_q <= cfg_wdata_i;
      end
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        ov_q <= v2_q;
        for (int i = 0; i < NUM_CH; i++) begin
          width_q[i] <= width_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted transaction not held in stage 1");

  a_stage2_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> ov_q)
    else $error("stage 2 transaction lost before output");

  a_widths_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> ($stable(width_q[0]) && $stable(width_q[1]) &&
                                  $stable(width_q[2]) && $stable(width_q[3])))
    else $error("stored widths changed while result stalled");

  a_no_update_without_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q |-> (upd == '0))
    else $error("width update without a stage 2 transaction");
`endif

endmodule
